@@ src/lpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed packet FIFO package
// Shared defaults, stream layout widths and the action and status codes.
// ----------------------------------------------------------------------------
package lpf_pkg;

  // Default geometry of the packet store.
  localparam int unsigned LPF_CAPACITY     = 65536;
  localparam int unsigned LPF_HEADER_BYTES = 4;

  // Stream layout.
  localparam int unsigned LPF_S_TDATA_W = 24;
  localparam int unsigned LPF_M_TDATA_W = 32;
  localparam int unsigned LPF_USED_W    = 17;

  // Action codes carried on the slave-side tuser.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Status codes carried on the master-side tuser.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;

endpackage

@@ src/lpf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its value.
// ----------------------------------------------------------------------------
module lpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/length_prefixed_packet_fifo_top.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed packet FIFO
// Circular byte store that keeps whole packets behind a little-endian length
// header; packets become readable only when their last byte has arrived.
// ----------------------------------------------------------------------------
// A payload write, a dropped byte, a clear or an idle code is handled in S_EXEC alone;
// a read byte also passes S_DATA_RD, and the first write or first read of a packet also passes S_HDR_WR or S_HDR_RD.
// The one RAM write port makes the header write one byte per cycle, and the
// registered RAM read sets the read path through S_DATA_RD. The result enters the output
// register in the item's last cycle and may wait there while the next beat is taken.
// Reset clears all pointers and counts at once; the RAM contents are not cleared.
module length_prefixed_packet_fifo_top
  import lpf_pkg::*;
#(
  parameter int unsigned CAPACITY     = LPF_CAPACITY,
  parameter int unsigned HEADER_BYTES = LPF_HEADER_BYTES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Slave side: one command beat.
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [LPF_S_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte, [23:8] packet_length
  input  logic [1:0]               s_axis_tuser_i,  // [1:0] action
  // Master side: one result beat per command.
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [LPF_M_TDATA_W-1:0] m_axis_tdata_o,  // [7:0] read_byte, [24:8] used_bytes,
                                                    // [31:25] zero
  output logic [1:0]               m_axis_tuser_o,  // [1:0] status
  output logic                     m_axis_tlast_o   // last_of_packet
);

  // Address width of the store, width of the byte count (it must hold CAPACITY
  // itself), and the widths used for the room check and header clamp.
  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned ROOM_W = ((CNT_W > 17) ? CNT_W : 17) + 1;
  localparam int unsigned HDR_W  = 8 * HEADER_BYTES;
  localparam int unsigned CMP_W  = (HDR_W > CNT_W) ? HDR_W : CNT_W;
  localparam int unsigned HIDX_W = $clog2(HEADER_BYTES);
  localparam int unsigned UEXT_W = CNT_W + LPF_USED_W;

  localparam logic [AW-1:0]     LAST_POS  = AW'(CAPACITY - 1);
  localparam logic [HIDX_W-1:0] HIDX_LAST = HIDX_W'(HEADER_BYTES - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;  // waiting for a command beat
  localparam logic [2:0] S_EXEC    = 3'd1;  // decode the command and act
  localparam logic [2:0] S_HDR_WR  = 3'd2;  // write the length header byte by byte
  localparam logic [2:0] S_HDR_RD  = 3'd3;  // collect the length header of a packet
  localparam logic [2:0] S_DATA_RD = 3'd4;  // RAM data for a payload read is present

  logic [2:0] state_q, state_d;

  // Pointers and counts. The byte count covers complete packets only, so a
  // partial packet at the write side is invisible to the read side.
  logic [AW-1:0]     rd_off_q, rd_off_d;
  logic [AW-1:0]     wr_off_q, wr_off_d;
  logic [CNT_W-1:0]  stored_q, stored_d;
  logic [15:0]       wr_left_q, wr_left_d;
  logic [15:0]       pend_len_q, pend_len_d;
  logic              dropping_q, dropping_d;
  logic [CNT_W-1:0]  rd_left_q, rd_left_d;
  logic [HIDX_W-1:0] hidx_q, hidx_d;

  // The command being worked on.
  logic [1:0]  act_q;
  logic [7:0]  dat_q;
  logic [15:0] len_q;

  // Header bytes gathered so far during a header read.
  logic [HDR_W-1:0] hdr_acc_q;
  logic [HDR_W-1:0] hdr_full;
  logic [CNT_W-1:0] hdr_clamped;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_rb_q;
  logic                  out_last_q;
  logic [1:0]            out_status_q;
  logic [LPF_USED_W-1:0] out_used_q, out_used_d;
  logic [UEXT_W-1:0]     used_ext;

  // RAM port signals.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  // Helpers.
  logic             s_accept;
  logic             slot_free;
  logic [AW-1:0]    rd_off_nxt, wr_off_nxt;
  logic [SUM_W-1:0] base_sum;
  logic [AW-1:0]    wr_base;
  logic             no_room;
  logic [31:0]      hdr_src;
  logic [7:0]       hdr_byte;

  // Finish request and result of the current command.
  logic             fin;
  logic [7:0]       fin_rb;
  logic             fin_last;
  logic [1:0]       fin_status;

  // Shared "start a payload read" step, used on a continuing packet and right
  // after a header has been collected.
  logic             start_rd;
  logic [CNT_W-1:0] rl_sel;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  // The command may finish once the output register is empty or being drained.
  // Only the current command can refill it, so this is checked once at decode.
  assign slot_free = !out_valid_q || m_axis_tready_i;

  assign rd_off_nxt = (rd_off_q == LAST_POS) ? '0 : rd_off_q + 1'b1;
  assign wr_off_nxt = (wr_off_q == LAST_POS) ? '0 : wr_off_q + 1'b1;

  // A new packet starts right after the last unread complete byte.
  assign base_sum = SUM_W'(rd_off_q) + SUM_W'(stored_q);
  assign wr_base  = (base_sum >= SUM_W'(CAPACITY)) ? AW'(base_sum - SUM_W'(CAPACITY))
                                                   : AW'(base_sum);

  assign no_room = (ROOM_W'(len_q) + ROOM_W'(HEADER_BYTES)) >
                   (ROOM_W'(CAPACITY) - ROOM_W'(stored_q));

  // Header bytes are the low bytes of the length, least significant first.
  assign hdr_src  = {16'd0, pend_len_q};
  assign hdr_byte = hdr_src[{hidx_q, 3'b000} +: 8];

  always_comb begin
    hdr_full = hdr_acc_q;
    hdr_full[{hidx_q, 3'b000} +: 8] = ram_rdata;
  end

  // A header never claims more than what is stored.
  assign hdr_clamped = (CMP_W'(hdr_full) > CMP_W'(stored_q)) ? stored_q : CNT_W'(hdr_full);

  always_comb begin
    state_d    = state_q;
    rd_off_d   = rd_off_q;
    wr_off_d   = wr_off_q;
    stored_d   = stored_q;
    wr_left_d  = wr_left_q;
    pend_len_d = pend_len_q;
    dropping_d = dropping_q;
    rd_left_d  = rd_left_q;
    hidx_d     = hidx_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = wr_off_q;
    ram_wdata  = dat_q;
    fin        = 1'b0;
    fin_rb     = '0;
    fin_last   = 1'b0;
    fin_status = ST_DONE;
    start_rd   = 1'b0;
    rl_sel     = rd_left_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
          unique case (act_q)
            ACT_WRITE: begin
              if (wr_left_q == '0) begin
                if (len_q == '0) begin
                  // A zero length at packet start is ignored.
                  fin = 1'b1;
                end else if (no_room) begin
                  // Discard the whole packet; its remaining bytes report a drop.
                  wr_left_d  = len_q - 16'd1;
                  dropping_d = (len_q != 16'd1);
                  fin        = 1'b1;
                  fin_status = ST_DROP;
                end else begin
                  // Lay down the header first; the payload byte follows when
                  // the sequencer comes back here with write_left nonzero.
                  wr_off_d   = wr_base;
                  pend_len_d = len_q;
                  wr_left_d  = len_q;
                  hidx_d     = '0;
                  state_d    = S_HDR_WR;
                end
              end else if (dropping_q) begin
                wr_left_d  = wr_left_q - 16'd1;
                dropping_d = (wr_left_q != 16'd1);
                fin        = 1'b1;
                fin_status = ST_DROP;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = dat_q;
                wr_off_d  = wr_off_nxt;
                wr_left_d = wr_left_q - 16'd1;
                if (wr_left_q == 16'd1) begin
                  // Packet complete: publish header and payload to the reader.
                  stored_d = stored_q + CNT_W'(HEADER_BYTES) + CNT_W'(pend_len_q);
                end
                fin = 1'b1;
              end
            end

            ACT_READ: begin
              if (rd_left_q == '0) begin
                if (stored_q <= CNT_W'(HEADER_BYTES)) begin
                  fin        = 1'b1;
                  fin_status = ST_EMPTY;
                end else begin
                  ram_re   = 1'b1;
                  rd_off_d = rd_off_nxt;
                  stored_d = stored_q - 1'b1;
                  hidx_d   = '0;
                  state_d  = S_HDR_RD;
                end
              end else begin
                start_rd = 1'b1;
              end
            end

            ACT_CLEAR: begin
              rd_off_d   = '0;
              wr_off_d   = '0;
              stored_d   = '0;
              wr_left_d  = '0;
              pend_len_d = '0;
              dropping_d = 1'b0;
              rd_left_d  = '0;
              fin        = 1'b1;
            end

            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_HDR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_byte;
        wr_off_d  = wr_off_nxt;
        if (hidx_q == HIDX_LAST) begin
          state_d = S_EXEC;
        end else begin
          hidx_d = hidx_q + 1'b1;
        end
      end

      S_HDR_RD: begin
        // Header reads are pipelined: one byte arrives while the next is issued.
        if (hidx_q == HIDX_LAST) begin
          rl_sel   = hdr_clamped;
          start_rd = 1'b1;
        end else begin
          ram_re   = 1'b1;
          rd_off_d = rd_off_nxt;
          stored_d = stored_q - 1'b1;
          hidx_d   = hidx_q + 1'b1;
        end
      end

      S_DATA_RD: begin
        fin      = 1'b1;
        fin_rb   = ram_rdata;
        fin_last = (rd_left_q == '0);
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (start_rd) begin
      if (rl_sel == '0 || stored_q == '0) begin
        rd_left_d  = '0;
        fin        = 1'b1;
        fin_status = ST_EMPTY;
        state_d    = S_IDLE;
      end else begin
        ram_re    = 1'b1;
        rd_off_d  = rd_off_nxt;
        stored_d  = stored_q - 1'b1;
        rd_left_d = rl_sel - 1'b1;
        state_d   = S_DATA_RD;
      end
    end
  end

  // Output register: used_bytes reports the count after the command, mod 2^17.
  assign used_ext   = UEXT_W'(stored_d);
  assign out_used_d = used_ext[LPF_USED_W-1:0];

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (fin) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_off_q    <= '0;
      wr_off_q    <= '0;
      stored_q    <= '0;
      wr_left_q   <= '0;
      pend_len_q  <= '0;
      dropping_q  <= 1'b0;
      rd_left_q   <= '0;
      hidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_off_q    <= rd_off_d;
      wr_off_q    <= wr_off_d;
      stored_q    <= stored_d;
      wr_left_q   <= wr_left_d;
      pend_len_q  <= pend_len_d;
      dropping_q  <= dropping_d;
      rd_left_q   <= rd_left_d;
      hidx_q      <= hidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      act_q <= s_axis_tuser_i;
      dat_q <= s_axis_tdata_i[7:0];
      len_q <= s_axis_tdata_i[23:8];
    end
    if (state_q == S_HDR_RD) begin
      hdr_acc_q <= hdr_full;
    end
    if (fin) begin
      out_rb_q     <= fin_rb;
      out_last_q   <= fin_last;
      out_status_q <= fin_status;
      out_used_q   <= out_used_d;
    end
  end

  lpf_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_lpf_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_off_q),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_used_q, out_rb_q};
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ src/lpf_checker.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed packet FIFO port checker
// Watches the top-level ports and flags illegal result beats.
// ----------------------------------------------------------------------------
module lpf_checker
  import lpf_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid_i,
  input logic                     s_axis_tready_o,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [LPF_M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]               m_axis_tuser_o,
  input logic                     m_axis_tlast_o
);

  // The command input is closed in the cycle after each accepted beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command input stayed open after an accepted beat");

  // A stalled result beat stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // Only a delivered payload byte can close a packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == ST_DONE)
    else $error("last marker on a beat that is not a completed read");

  // Empty and drop results carry no byte and no last marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_EMPTY || m_axis_tuser_o == ST_DROP) |->
      m_axis_tdata_o[7:0] == 8'd0 && !m_axis_tlast_o)
    else $error("byte or last marker on an empty or drop result");

  // The unused status code is never produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o == ST_DONE || m_axis_tuser_o == ST_EMPTY ||
      m_axis_tuser_o == ST_DROP)
    else $error("undefined status code on a result beat");

endmodule

bind length_prefixed_packet_fifo_top lpf_checker u_lpf_checker (.*);

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Length-prefixed packet FIFO testbench
// Streams write, read, clear and idle-code beats into the packet FIFO and
// checks every result beat, field by field, against a cycle-free model of the
// packet store. Both streams idle at random and the result side holds off
// once for a long stretch so that the FIFO backs up into its command input.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpf_pkg::*;

  // The package has no name for the unused action code.
  localparam logic [1:0]  ACT_NONE   = 2'd3;
  localparam int unsigned STORE_SIZE = LPF_CAPACITY;
  localparam int unsigned HDR_BYTES  = LPF_HEADER_BYTES;
  localparam int unsigned PTR_W      = $clog2(LPF_CAPACITY);
  localparam int unsigned MAX_GAP    = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_BEATS = 1500;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct {
    logic [1:0]  act;
    logic [7:0]  data;
    logic [15:0] plen;
    int unsigned gap;
  } cmd_beat_t;

  typedef struct packed {
    logic [7:0]            rbyte;
    logic                  is_last;
    logic [1:0]            status;
    logic [LPF_USED_W-1:0] used;
  } fifo_result_t;

  logic                     clk_i   = 1'b0;
  logic                     rst_ni  = 1'b0;
  logic                     s_valid = 1'b0;
  logic [LPF_S_TDATA_W-1:0] s_data  = '0;
  logic [1:0]               s_user  = '0;
  logic                     s_ready;
  logic                     m_valid;
  logic                     m_ready = 1'b0;
  logic [LPF_M_TDATA_W-1:0] m_data;
  logic [1:0]               m_user;
  logic                     m_last;

  length_prefixed_packet_fifo_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Packet store model. Pointers are PTR_W bits wide, so they wrap at the
  // store size on their own; the store size is a power of two.
  // --------------------------------------------------------------------------
  logic [7:0]            pkt_mem [STORE_SIZE];
  logic [PTR_W-1:0]      rd_ptr   = '0;
  logic [PTR_W-1:0]      wr_ptr   = '0;
  logic [LPF_USED_W-1:0] held     = '0;
  logic [15:0]           wr_left  = '0;
  logic [15:0]           pend_len = '0;
  logic [15:0]           rd_left  = '0;
  logic                  dropping = 1'b0;

  function automatic void put_stored_byte(logic [7:0] b);
    pkt_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  function automatic logic [7:0] take_stored_byte();
    logic [7:0] b;
    b = pkt_mem[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    if (held != 0) held = held - 1'b1;
    return b;
  endfunction

  function automatic logic [1:0] store_write(logic [7:0] din, logic [15:0] plen);
    if (wr_left == 0) begin
      // A zero length at a packet boundary starts nothing.
      if (plen == 0) return ST_DONE;
      // Header and payload must fit the free space, checked once per packet.
      if (32'(plen) + HDR_BYTES > STORE_SIZE - 32'(held)) begin
        wr_left  = plen - 1'b1;
        dropping = (wr_left != 0);
        return ST_DROP;
      end
      wr_ptr   = PTR_W'((32'(rd_ptr) + 32'(held)) % STORE_SIZE);
      pend_len = plen;
      for (int i = 0; i < HDR_BYTES; i++) put_stored_byte(8'(32'(plen) >> (8 * i)));
      wr_left = plen;
    end else if (dropping) begin
      wr_left = wr_left - 1'b1;
      if (wr_left == 0) dropping = 1'b0;
      return ST_DROP;
    end
    put_stored_byte(din);
    wr_left = wr_left - 1'b1;
    // The packet becomes visible to reads only with its final byte.
    if (wr_left == 0) held = held + LPF_USED_W'(HDR_BYTES) + LPF_USED_W'(pend_len);
    return ST_DONE;
  endfunction

  function automatic fifo_result_t packet_store_step(logic [1:0] act, logic [7:0] din,
                                                     logic [15:0] plen);
    fifo_result_t r;
    logic [31:0]  hdr;
    r = '0;
    case (act)
      ACT_WRITE: r.status = store_write(din, plen);
      ACT_READ: begin
        if (rd_left == 0) begin
          if (held <= HDR_BYTES) begin
            r.status = ST_EMPTY;
          end else begin
            // The header goes by silently on the first read of a packet.
            hdr = '0;
            for (int i = 0; i < HDR_BYTES; i++) hdr |= 32'(take_stored_byte()) << (8 * i);
            if (hdr > 32'(held)) hdr = 32'(held);
            rd_left = 16'(hdr);
          end
        end
        if (r.status == ST_DONE) begin
          if (rd_left == 0 || held == 0) begin
            rd_left  = '0;
            r.status = ST_EMPTY;
          end else begin
            r.rbyte   = take_stored_byte();
            rd_left   = rd_left - 1'b1;
            r.is_last = (rd_left == 0);
          end
        end
      end
      ACT_CLEAR: begin
        rd_ptr   = '0;
        wr_ptr   = '0;
        held     = '0;
        wr_left  = '0;
        pend_len = '0;
        rd_left  = '0;
        dropping = 1'b0;
      end
      default: ;
    endcase
    r.used = held;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command list, built in full at time zero. Each beat carries its own idle
  // gap on the command side; the matching result pause goes to its own queue.
  // --------------------------------------------------------------------------
  cmd_beat_t    cmd_beats[$];
  int unsigned  ready_pauses[$];
  fifo_result_t due_results[$];
  bit           quiet = 1'b0;
  longint unsigned cycle_budget = 0;
  longint unsigned cycle_limit  = 64'hFFFF_FFFF_FFFF;
  longint unsigned cycle_count  = 0;
  int unsigned  hold_at = 0;

  function automatic int unsigned pick_gap();
    return quiet ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void push_cmd(logic [1:0] act, logic [7:0] data, logic [15:0] plen);
    cmd_beat_t c;
    int unsigned pause;
    c.act  = act;
    c.data = data;
    c.plen = plen;
    c.gap  = pick_gap();
    pause  = pick_gap();
    cmd_beats.push_back(c);
    ready_pauses.push_back(pause);
    // Worst case per beat: the first byte of a packet plus both gaps.
    cycle_budget += 8 + c.gap + pause;
  endfunction

  function automatic void send_reads(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      push_cmd(ACT_READ, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endfunction

  // Sends the first 'sent' bytes of a packet of length plen. The length field
  // of the later bytes is ignored by the FIFO, so it gets random noise. With a
  // nonzero read_odds, reads are slipped in between the bytes now and then.
  function automatic void send_packet(int unsigned plen, int unsigned sent,
                                      int unsigned read_odds);
    for (int unsigned i = 0; i < sent; i++) begin
      push_cmd(ACT_WRITE, 8'($urandom_range(0, 255)),
               (i == 0) ? 16'(plen) : 16'($urandom_range(0, 65535)));
      if (read_odds != 0 && $urandom_range(1, read_odds) == 1) send_reads(1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Command driver.
  // --------------------------------------------------------------------------
  cmd_beat_t   cur;
  bit          holding  = 1'b0;
  int unsigned gap_left = 0;
  int unsigned n_accepted = 0;
  int unsigned n_writes = 0, n_reads = 0, n_clears = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        due_results.push_back(packet_store_step(cur.act, cur.data, cur.plen));
        n_accepted++;
        case (cur.act)
          ACT_WRITE: n_writes++;
          ACT_READ:  n_reads++;
          ACT_CLEAR: n_clears++;
          default: ;
        endcase
        holding = 1'b0;
      end
      if (!holding && cmd_beats.size() != 0) begin
        cur      = cmd_beats.pop_front();
        holding  = 1'b1;
        gap_left = cur.gap;
      end
      if (holding && gap_left == 0) begin
        s_valid <= 1'b1;
        s_data  <= {cur.plen, cur.data};
        s_user  <= cur.act;
      end else begin
        s_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and checker.
  // --------------------------------------------------------------------------
  int unsigned n_results = 0, n_errors = 0;
  int unsigned n_drops = 0, n_empties = 0, n_packets_out = 0, peak_used = 0;
  int unsigned stall_left = 0;

  function automatic void flag_field(string field, int unsigned want, logic [31:0] got);
    n_errors++;
    if (n_errors <= MAX_REPORTS)
      $display("%0t ns: result %0d %s expected %0d, got %0d",
               $time, n_results, field, want, got);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    fifo_result_t want;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        n_results++;
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t ns: result beat with nothing expected, expected none, got tdata %h",
                     $time, m_data);
        end else begin
          want = due_results.pop_front();
          if (m_data[7:0] !== want.rbyte) flag_field("read_byte", want.rbyte, m_data[7:0]);
          if (m_last !== want.is_last) flag_field("last_of_packet", want.is_last, m_last);
          if (m_user !== want.status) flag_field("status", want.status, m_user);
          if (m_data[8 +: LPF_USED_W] !== want.used)
            flag_field("used_bytes", want.used, m_data[8 +: LPF_USED_W]);
          if (m_data[LPF_M_TDATA_W-1:8+LPF_USED_W] !== '0)
            flag_field("tdata pad", 0, m_data[LPF_M_TDATA_W-1:8+LPF_USED_W]);
          if (want.status == ST_DROP) n_drops++;
          if (want.status == ST_EMPTY) n_empties++;
          if (want.is_last) n_packets_out++;
          if (want.used > peak_used) peak_used = want.used;
        end
        stall_left = (ready_pauses.size() != 0) ? ready_pauses.pop_front() : 0;
        // One long hold-off: the FIFO keeps taking commands until it backs up.
        if (n_results == hold_at) stall_left += HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned avail, n_real, n_prev, pick, plen, n, n_total;

    // Directed beats: empty read, unused code, zero length, reads that must
    // not see a partial packet, maximum length accepted and then abandoned,
    // a dropped packet abandoned by clear, and a clear in the middle of a read.
    send_reads(1);
    push_cmd(ACT_NONE, 8'hFF, 16'hFFFF);
    push_cmd(ACT_WRITE, 8'h00, 16'd0);
    push_cmd(ACT_WRITE, 8'hFF, 16'd1);
    push_cmd(ACT_WRITE, 8'h00, 16'd3);
    send_reads(2);
    push_cmd(ACT_WRITE, 8'h5A, 16'hFFFF);
    push_cmd(ACT_WRITE, 8'hA5, 16'h0000);
    send_reads(4);
    push_cmd(ACT_WRITE, 8'h11, 16'd65532);
    push_cmd(ACT_WRITE, 8'h22, 16'hFFFF);
    push_cmd(ACT_CLEAR, 8'hFF, 16'hFFFF);
    send_packet(2, 2, 0);
    push_cmd(ACT_WRITE, 8'h33, 16'd65532);
    push_cmd(ACT_WRITE, 8'h44, 16'd7);
    push_cmd(ACT_CLEAR, 8'h00, 16'd0);
    send_reads(1);
    send_packet(2, 2, 0);
    send_reads(1);
    push_cmd(ACT_CLEAR, 8'h00, 16'd0);
    send_reads(1);

    // Random part: mostly whole packets and read bursts, with some clears,
    // abandoned packets and ignored beats mixed in.
    hold_at = cmd_beats.size() + 100;
    cycle_budget += HOLD_CYCLES;
    avail  = 0;
    n_real = 0;
    while (n_real < RANDOM_BEATS) begin
      quiet  = ($urandom_range(0, 4) == 0);
      pick   = $urandom_range(0, 99);
      n_prev = cmd_beats.size();
      if (pick < 55) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        send_packet(plen, plen, 6);
        avail += plen;
      end else if (pick < 83) begin
        n = $urandom_range(1, avail + 2);
        send_reads(n);
        avail = (n > avail) ? 0 : avail - n;
      end else if (pick < 88) begin
        push_cmd(ACT_CLEAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        avail = 0;
      end else if (pick < 94) begin
        plen = $urandom_range(2, 40);
        send_packet(plen, $urandom_range(1, plen - 1), 4);
        push_cmd(ACT_CLEAR, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
        avail = 0;
      end else begin
        // Ignored beats do not count toward the random total.
        if (pick < 97) push_cmd(ACT_NONE, 8'($urandom_range(0, 255)),
                                16'($urandom_range(0, 65535)));
        else push_cmd(ACT_WRITE, 8'($urandom_range(0, 255)), 16'd0);
        n_prev = cmd_beats.size();
      end
      n_real += cmd_beats.size() - n_prev;
    end

    n_total     = cmd_beats.size();
    cycle_limit = 4 * cycle_budget + 1000;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total || due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d beats: %0d writes, %0d reads, %0d clears, %0d packets read out.",
             n_total, n_writes, n_reads, n_clears, n_packets_out);
    $display("Saw %0d dropped-byte results, %0d empty reads, peak occupancy %0d bytes.",
             n_drops, n_empties, peak_used);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
